// File: design/ilp_pkg.sv
package ilp_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 64;
  localparam int RESULT_WIDTH        = 64;

  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_HEX = 2'd1;
  localparam logic [1:0] MODE_BIN = 2'd2;

  localparam logic [1:0] POS_MAX = 2'd2;

  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  typedef struct packed {
    logic [1:0] radix_mode;
    logic [1:0] char_position;
    logic       negative_sign;
    logic       first_was_zero;
    logic       parsing_stopped;
    logic       overflowed;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    radix_mode:      MODE_DEC,
    char_position:   2'd0,
    negative_sign:   1'b0,
    first_was_zero:  1'b0,
    parsing_stopped: 1'b0,
    overflowed:      1'b0
  };

endpackage

// File: design/ilp_char_step.sv
module ilp_char_step #(
  parameter int VALUE_WIDTH = ilp_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic [7:0]             char_byte,
  input  ilp_pkg::ctl_t          ctl,
  input  logic [VALUE_WIDTH-1:0] acc,
  output ilp_pkg::ctl_t          ctl_next,
  output logic [VALUE_WIDTH-1:0] acc_next
);
  import ilp_pkg::*;

  logic                   is_dec;
  logic                   is_uhex;
  logic                   is_lhex;
  logic                   is_digit;
  logic                   is_skip;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] scaled;
  logic [VALUE_WIDTH-1:0] sum;

  assign is_dec  = (char_byte >= CH_0) && (char_byte <= CH_9);
  assign is_uhex = (char_byte >= CH_UA) && (char_byte <= CH_UF);
  assign is_lhex = (char_byte >= CH_LA) && (char_byte <= CH_LF);

  always_comb begin
    is_digit = 1'b0;
    is_skip  = 1'b0;
    digit    = 4'd0;
    if (is_dec) begin
      is_digit = 1'b1;
      digit    = 4'(char_byte - CH_0);
    end else if (ctl.radix_mode == MODE_HEX) begin
      if (is_uhex) begin
        is_digit = 1'b1;
        digit    = 4'(char_byte - CH_UA + 8'd10);
      end else if (is_lhex) begin
        is_digit = 1'b1;
        digit    = 4'(char_byte - CH_LA + 8'd10);
      end
    end else if (char_byte == CH_UNDER) begin
      is_skip = 1'b1;
    end
  end

  // multiply by constant radix as shifts and adds
  always_comb begin
    case (ctl.radix_mode)
      MODE_HEX: scaled = acc << 4;
      MODE_BIN: scaled = acc << 1;
      default:  scaled = (acc << 3) + (acc << 1);
    endcase
  end

  assign sum = scaled + VALUE_WIDTH'(digit);

  always_comb begin
    ctl_next = ctl;
    acc_next = acc;
    if (!ctl.parsing_stopped) begin
      if (ctl.char_position == 2'd0 && char_byte == CH_MINUS) begin
        ctl_next.negative_sign = 1'b1;
      end else if (ctl.char_position == 2'd1 && ctl.first_was_zero &&
                   (char_byte == CH_X || char_byte == CH_B)) begin
        ctl_next.radix_mode = (char_byte == CH_X) ? MODE_HEX : MODE_BIN;
      end else begin
        if (ctl.char_position == 2'd0 && char_byte == CH_0) begin
          ctl_next.first_was_zero = 1'b1;
        end
        if (is_digit) begin
          acc_next = sum;
          if (sum < acc) begin
            ctl_next.overflowed      = 1'b1;
            ctl_next.parsing_stopped = 1'b1;
          end
        end else if (!is_skip) begin
          ctl_next.parsing_stopped = 1'b1;
        end
      end
    end
    if (ctl.char_position != POS_MAX) begin
      ctl_next.char_position = ctl.char_position + 2'd1;
    end
  end

endmodule

// File: design/integer_literal_parser.sv
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  char_byte, last_char
// out      from block out_valid/out_stall  parsed_value, parse_ok
//
// One item per cycle sustained while in_stall stays low.
// Input register, then one shift-add step on the accumulator into the result register.
// Items without last_char never wait on the output side.
// rst is synchronous and clears the parse state and both valid flags.
// in_stall rises only when a last item is held behind an untaken result.
module integer_literal_parser #(
  parameter int VALUE_WIDTH = ilp_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          char_byte,
  input  logic                                last_char,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ilp_pkg::RESULT_WIDTH-1:0] parsed_value,
  output logic                                parse_ok
);
  import ilp_pkg::*;

  logic                   a_valid;
  logic [7:0]             a_char;
  logic                   a_last;
  logic                   a_move;
  logic                   in_accept;
  ctl_t                   ctl;
  ctl_t                   ctl_step;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic [VALUE_WIDTH-1:0] value_w;

  ilp_char_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step (
    .char_byte (a_char),
    .ctl       (ctl),
    .acc       (acc),
    .ctl_next  (ctl_step),
    .acc_next  (acc_step)
  );

  assign a_move    = a_valid && (!a_last || !out_valid || !out_stall);
  assign in_stall  = a_valid && !a_move;
  assign in_accept = in_valid && !in_stall;

  assign value_w = ctl_step.negative_sign ? (~acc_step + VALUE_WIDTH'(1)) : acc_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_accept || (a_valid && !a_move);
    end
    if (in_accept) begin
      a_char <= char_byte;
      a_last <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= CTL_RESET;
      acc <= '0;
    end else if (a_move) begin
      if (a_last) begin
        ctl <= CTL_RESET;
        acc <= '0;
      end else begin
        ctl <= ctl_step;
        acc <= acc_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move && a_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (a_move && a_last) begin
      if (ctl_step.overflowed) begin
        parsed_value <= '0;
        parse_ok     <= 1'b0;
      end else begin
        parsed_value <= RESULT_WIDTH'(signed'(value_w));
        parse_ok     <= 1'b1;
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !parse_ok |-> parsed_value == '0)
    else $error("failed parse with nonzero value");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && a_last && out_valid)
    else $error("input stalled without a held last item");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    a_move && a_last |=> ctl == CTL_RESET && acc == '0)
    else $error("parse state not cleared after last item");

  a_ovf_stops: assert property (@(posedge clk) disable iff (rst)
    ctl.overflowed |-> ctl.parsing_stopped)
    else $error("overflow without stop");

  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    ctl.char_position != 2'd3)
    else $error("char position beyond saturation");

endmodule
